// ===== rtl/core/strict_priority_multi_fifo_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SPMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spmf_pkg.sv =====
`timescale 1ns / 1ps

package spmf_pkg;

    // Operation carried in the slave tuser bit
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status carried in the master tuser field
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Fixed field widths of the stream payloads
    localparam int PRIO_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Item sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH
    } t_state;

endpackage

// ===== rtl/core/strict_priority_multi_fifo.sv =====
`timescale 1ns / 1ps
// Strict-priority queue of LEVELS circular FIFOs, each DEPTH entries deep.
// Slave stream: tuser = operation (insert or remove), tdata = level and value.
// Master stream: one result beat per accepted beat, tdata = value, level and
// pending flag, tuser = status (ok, level full, all empty).
// Insert stores the value at the tail of its level (levels above LEVELS-1
// saturate). Remove returns the oldest value of the highest non-empty level.
// An insert or a rejected request passes the registered pointer table read and
// the output register; a remove that returns a value also passes the registered
// entry memory read between them. One item is in flight at a time: no new beat
// is taken until the current one has reached the output register.
// Reset clears the non-empty mask and the pointer table valid bits and holds
// tready low; all levels read as empty at once. The entry memory is not cleared.
// A stalled result beat holds in the output register; no new beat is taken
// until the held result is accepted.
module strict_priority_multi_fifo #(
    parameter int LEVELS     = 26,
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [4:0] priority_req, [36:5] value, [39:37] zero
    input  logic [spmf_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] opcode
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] out_value, [36:32] out_priority, [37] any_pending, [39:38] zero
    output logic [spmf_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [1:0] status
    output logic [spmf_pkg::STATUS_W-1:0]  o_m_tuser
);

    import spmf_pkg::*;

    localparam int LVW = $clog2(LEVELS);
    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int TW  = CW + 2 * PW;
    localparam int WORDS = LEVELS * DEPTH;
    localparam int AW  = $clog2(WORDS);

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        f_next = (32'(p) + 32'd1 >= 32'(DEPTH)) ? '0 : p + 1'b1;
    endfunction

    t_state r_state, n_state;

    logic                  r_op;
    logic [LVW-1:0]        r_lv;
    logic [AW-1:0]         r_base;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic                  r_empty;
    logic [LEVELS-1:0]     r_mask, n_mask;

    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value, n_out_value;
    logic [PRIO_W-1:0]     r_out_prio, n_out_prio;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic                  r_out_pend;
    logic                  load_out;

    logic                  s_ready;
    logic                  s_accept;
    logic                  in_op;
    logic [PRIO_W-1:0]     in_prio;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [63:0]    in_ext;

    logic [LVW-1:0]        enc_lv;
    logic                  enc_any;
    logic [LVW-1:0]        sat_lv;
    logic [LVW-1:0]        n_lv;

    logic [TW-1:0]         tbl_rd_data;
    logic                  tbl_wr_en;
    logic [TW-1:0]         tbl_wr_data;
    logic [PW-1:0]         tbl_head;
    logic [PW-1:0]         tbl_tail;
    logic [CW-1:0]         tbl_count;

    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;
    logic signed [DATA_WIDTH-1:0] ram_rd_signed;
    logic signed [63:0]    out_ext;

    // Unpack the input beat
    assign in_op    = i_s_tuser;
    assign in_prio  = i_s_tdata[PRIO_W-1:0];
    assign in_value = i_s_tdata[PRIO_W +: VALUE_W];
    assign in_ext   = 64'(in_value);

    // Highest non-empty level
    always_comb begin
        enc_lv  = '0;
        enc_any = |r_mask;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_mask[i]) begin
                enc_lv = LVW'(i);
            end
        end
    end

    // Saturate the requested level
    always_comb begin
        if (32'(in_prio) > 32'(LEVELS - 1)) begin
            sat_lv = LVW'(LEVELS - 1);
        end else begin
            sat_lv = LVW'(in_prio);
        end
    end

    assign n_lv = (in_op == OP_INSERT) ? sat_lv : enc_lv;

    // Split the level record
    assign tbl_head  = tbl_rd_data[PW-1:0];
    assign tbl_tail  = tbl_rd_data[2*PW-1:PW];
    assign tbl_count = tbl_rd_data[TW-1:2*PW];

    // Take a beat only out of reset, when idle and with room for its result
    assign s_ready  = i_rst_n && (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign s_accept = i_s_tvalid && s_ready;

    assign ram_rd_signed = ram_rd_data;
    assign out_ext       = 64'(ram_rd_signed);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (r_op == OP_REMOVE && !r_empty) begin
                    n_state = ST_FETCH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table and memory accesses, result formation
    always_comb begin
        tbl_wr_en    = 1'b0;
        tbl_wr_data  = tbl_rd_data;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_addr     = r_base;
        n_mask       = r_mask;
        load_out     = 1'b0;
        n_out_value  = '0;
        n_out_prio   = '0;
        n_out_status = STAT_OK;
        case (r_state)
            ST_LOOKUP: begin
                load_out = (r_op == OP_INSERT) || r_empty;
                if (r_op == OP_INSERT) begin
                    if (tbl_count == CW'(DEPTH)) begin
                        n_out_status = STAT_FULL;
                    end else begin
                        ram_wr_en    = 1'b1;
                        ram_addr     = r_base + AW'(tbl_tail);
                        tbl_wr_en    = 1'b1;
                        tbl_wr_data  = {tbl_count + 1'b1, f_next(tbl_tail), tbl_head};
                        n_mask[r_lv] = 1'b1;
                    end
                end else if (r_empty) begin
                    n_out_status = STAT_EMPTY;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_addr    = r_base + AW'(tbl_head);
                    tbl_wr_en   = 1'b1;
                    tbl_wr_data = {tbl_count - 1'b1, tbl_tail, f_next(tbl_head)};
                    if (tbl_count == CW'(1)) begin
                        n_mask[r_lv] = 1'b0;
                    end
                end
            end
            ST_FETCH: begin
                load_out    = 1'b1;
                n_out_value = out_ext[VALUE_W-1:0];
                n_out_prio  = PRIO_W'(r_lv);
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // Sequencer and mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mask  <= '0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op    <= in_op;
            r_lv    <= n_lv;
            r_base  <= AW'(32'(n_lv) * 32'(DEPTH));
            r_wdata <= in_ext[DATA_WIDTH-1:0];
            r_empty <= !enc_any;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value  <= n_out_value;
            r_out_prio   <= n_out_prio;
            r_out_status <= n_out_status;
            r_out_pend   <= |n_mask;
        end
    end

    spmf_level_table #(
        .LEVELS (LEVELS),
        .WIDTH  (TW)
    ) u_level_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (n_lv),
        .o_rd_data (tbl_rd_data),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_lv),
        .i_wr_data (tbl_wr_data)
    );

    spmf_entry_ram #(
        .WORDS      (WORDS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data (r_wdata),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_pend, r_out_prio, r_out_value};
    assign o_m_tuser  = r_out_status;

endmodule

// ===== rtl/core/spmf_entry_ram.sv =====
`timescale 1ns / 1ps

module spmf_entry_ram #(
    parameter int WORDS      = 3328,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(WORDS)-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0]    i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(WORDS)-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0]    o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [WORDS];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/spmf_level_table.sv =====
`timescale 1ns / 1ps

module spmf_level_table #(
    parameter int LEVELS = 26,
    parameter int WIDTH  = 22
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [$clog2(LEVELS)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data,
    input  logic                      i_wr_en,
    input  logic [$clog2(LEVELS)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]          i_wr_data
);

    logic [WIDTH-1:0]  r_mem [LEVELS];
    logic [LEVELS-1:0] r_vld;
    logic [WIDTH-1:0]  r_rd_data;
    logic              r_rd_vld;

    // Write a level record
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark records written since reset; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/core/spmf_checker.sv =====
`timescale 1ns / 1ps
`include "strict_priority_multi_fifo_macros.svh"

module spmf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [spmf_pkg::S_DATA_W-1:0]  i_s_tdata,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [spmf_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic [spmf_pkg::STATUS_W-1:0]  o_m_tuser
);

    import spmf_pkg::*;

    // A stalled result beat holds
    `SPMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result beat changed while stalled")

    // One item in flight: no beat taken right after another
    `SPMF_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while an item is in flight")

    // Rejected remove: nothing pending and no payload
    `SPMF_ASSERT_NOW(a_empty_result, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == STAT_EMPTY, o_m_tdata[37:0] == 38'd0, "empty status with payload or pending flag")

    // Rejected insert: the full level is still pending
    `SPMF_ASSERT_NOW(a_full_result, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == STAT_FULL, o_m_tdata[37] && o_m_tdata[36:0] == 37'd0, "full status without pending flag")

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (.*);
